### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the checker files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define PSWC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle.
`define PSWC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/pswc_pkg.sv
// ----------------------------------------------------------------------------
// pswc_pkg
// Types, codes, sine table and helper function of the column walker.
// ----------------------------------------------------------------------------
package pswc_pkg;

  localparam int SineEntries = 64;

  localparam logic signed [11:0] SINE_TBL [0:SineEntries] = '{
    12'sd0, 12'sd100, 12'sd200, 12'sd297, 12'sd392, 12'sd483, 12'sd569, 12'sd650,
    12'sd724, 12'sd792, 12'sd851, 12'sd903, 12'sd946, 12'sd980, 12'sd1004, 12'sd1019,
    12'sd1024, 12'sd1019, 12'sd1004, 12'sd980, 12'sd946, 12'sd903, 12'sd851, 12'sd792,
    12'sd724, 12'sd650, 12'sd569, 12'sd483, 12'sd392, 12'sd297, 12'sd200, 12'sd100,
    12'sd0, -12'sd100, -12'sd200, -12'sd297, -12'sd392, -12'sd483, -12'sd569, -12'sd650,
    -12'sd724, -12'sd792, -12'sd851, -12'sd903, -12'sd946, -12'sd980, -12'sd1004,
    -12'sd1019, -12'sd1024, -12'sd1019, -12'sd1004, -12'sd980, -12'sd946, -12'sd903,
    -12'sd851, -12'sd792, -12'sd724, -12'sd650, -12'sd569, -12'sd483, -12'sd392,
    -12'sd297, -12'sd200, -12'sd100, 12'sd0
  };

  localparam logic [9:0] QUARTER_TURN = 10'd256;

  typedef enum logic [2:0] {
    CFG_CAM_DIST  = 3'd0,
    CFG_CAM_FIXED = 3'd1,
    CFG_DISP_TOP  = 3'd2,
    CFG_TILT      = 3'd3,
    CFG_AXIS_LEN  = 3'd4
  } cfg_idx_t;

  typedef enum logic {
    OP_BEGIN   = 1'b0,
    OP_ADVANCE = 1'b1
  } op_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_B_TILT, ST_B_ZO, ST_B_LC, ST_B_LS, ST_B_XN,
    ST_B_N1, ST_B_N2, ST_B_D1, ST_B_D2, ST_B_D3,
    ST_FDIV, ST_DIVW, ST_M_SC, ST_SC, ST_RES
  } state_t;

  typedef enum logic [1:0] {
    PH_XP, PH_SRC, PH_SC
  } phase_t;

  typedef struct packed {
    logic               start;
    logic signed [31:0] num;
    logic signed [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] quot;
  } div_rsp_t;

  // Interpolated sine in Q10, 1024 steps per turn.
  function automatic logic signed [11:0] sine_lookup(input logic [9:0] ang);
    logic [5:0]         idx;
    logic [3:0]         frac;
    logic signed [11:0] base;
    logic signed [11:0] grad;
    logic signed [16:0] prod;
    logic signed [16:0] bias;
    idx  = ang[9:4];
    frac = ang[3:0];
    base = SINE_TBL[idx];
    grad = SINE_TBL[{1'b0, idx} + 7'd1] - base;
    prod = 17'(grad * $signed({1'b0, frac}));
    bias = prod + (prod[16] ? 17'sd15 : 17'sd0);
    return base + 12'(bias >>> 4);
  endfunction

endpackage

### hdl/pswc_if.sv
// ----------------------------------------------------------------------------
// pswc_in_if / pswc_out_if
// Valid-ready channels carrying input and result beats.
// ----------------------------------------------------------------------------
interface pswc_in_if;
  logic               valid;
  logic               ready;
  logic               operation;
  logic signed [10:0] angle;
  logic signed [10:0] depth_distance;
  logic signed [31:0] centre_position;
  logic [10:0]        slide_width;

  modport source(output valid, operation, angle, depth_distance, centre_position,
                 slide_width, input ready);
  modport sink(input valid, operation, angle, depth_distance, centre_position,
               slide_width, output ready);
endinterface

interface pswc_out_if;
  logic        valid;
  logic        ready;
  logic [10:0] screen_row;
  logic        visible;
  logic [9:0]  source_row;
  logic [30:0] cross_scale;
  logic        finished;

  modport source(output valid, screen_row, visible, source_row, cross_scale, finished,
                 input ready);
  modport sink(input valid, screen_row, visible, source_row, cross_scale, finished,
               output ready);
endinterface

### hdl/pswc_div.sv
// ----------------------------------------------------------------------------
// pswc_div
// Radix-2 restoring signed divider, truncating toward zero. It runs 32
// iteration steps and raises done in the cycle after the last one.
// A zero divisor gives a zero quotient.
// ----------------------------------------------------------------------------
module pswc_div
  import pswc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic        busy_r;
  logic        done_r;
  logic [5:0]  cnt_r;
  logic [32:0] rem_r;
  logic [31:0] quo_r;
  logic [31:0] dmag_r;
  logic        neg_r;
  logic        zero_r;
  logic [32:0] shifted;
  logic        fits;

  assign shifted = {rem_r[31:0], quo_r[31]};
  assign fits    = shifted >= {1'b0, dmag_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'd32;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r  <= req.num[31] ? 32'(-req.num) : req.num;
      dmag_r <= req.den[31] ? 32'(-req.den) : req.den;
      neg_r  <= req.num[31] ^ req.den[31];
      zero_r <= req.den == 32'sd0;
      rem_r  <= '0;
    end else if (busy_r) begin
      rem_r <= fits ? shifted - {1'b0, dmag_r} : shifted;
      quo_r <= {quo_r[30:0], fits};
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = zero_r ? 32'sd0 : (neg_r ? $signed(-quo_r) : $signed(quo_r));

endmodule

### hdl/pswc_mul.sv
// ----------------------------------------------------------------------------
// pswc_mul
// Shared signed 32 by 32 multiplier with a registered 64-bit product.
// ----------------------------------------------------------------------------
module pswc_mul (
  input  logic               clk,
  input  logic signed [31:0] op_a,
  input  logic signed [31:0] op_b,
  output logic signed [63:0] prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

endmodule

### hdl/perspective_slide_column_walker_unit.sv
// ----------------------------------------------------------------------------
// perspective_slide_column_walker_unit
// Perspective row walker for a rotated slide, built around one multiplier
// and one iterative divider under a sequencer.
// ----------------------------------------------------------------------------
// Channel   Dir  Beat contents
// in_chan   in   operation, angle, depth_distance, centre_position, slide_width
// out_chan  out  screen_row, visible, source_row, cross_scale, finished
// cfg_*     in   write enable, register index, 32-bit data
//
// A begin beat runs up to three divides among its multiplier steps, a rotated
// advance up to two and an unrotated one at most one; a finished advance goes
// straight to the result.
// Reset is synchronous and active low. The block takes one beat at a time;
// a finished result waits in the output register while out_chan stalls.
// ----------------------------------------------------------------------------
module perspective_slide_column_walker_unit
  import pswc_pkg::*;
#(
  parameter int FRAC_BITS = 10
) (
  input  logic              clk,
  input  logic              rst_n,
  pswc_in_if.sink           in_chan,
  pswc_out_if.source        out_chan,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_data
);

  localparam int SW = $clog2(FRAC_BITS + 1);
  localparam logic signed [31:0] ONE_Q = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [33:0] ONE_M1 = 34'(ONE_Q - 32'sd1);

  state_t state_r, state_nxt;
  phase_t phase_r;

  logic [15:0]        cam_r;
  logic [25:0]        camfx_r;
  logic signed [31:0] top_r;
  logic signed [31:0] tilt_r;
  logic [10:0]        axis_r;

  logic [10:0]        angle_r;
  logic signed [10:0] dist_r;
  logic signed [31:0] cx_r;
  logic [10:0]        win_r;

  logic [10:0]        width_r;
  logic signed [31:0] left_r;
  logic signed [11:0] cos_r;
  logic signed [11:0] sin_r;
  logic signed [31:0] zo_r;
  logic               rot_r;
  logic signed [31:0] num_r;
  logic signed [31:0] den_r;
  logic signed [31:0] src_r;
  logic signed [31:0] step_r;
  logic [10:0]        row_r;

  logic signed [31:0] t_r;
  logic signed [31:0] xp_r;
  logic signed [31:0] divn_r;
  logic signed [31:0] divd_r;
  logic [30:0]        sc_r;

  logic               out_valid_r;
  logic [10:0]        o_row_r;
  logic               o_vis_r;
  logic [9:0]         o_src_r;
  logic [30:0]        o_sc_r;
  logic               o_fin_r;

  logic               in_acc;
  logic               out_free;
  logic signed [31:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [63:0] prod_r;
  div_req_t           dreq;
  div_rsp_t           drsp;

  logic signed [31:0] cam_s;
  logic signed [31:0] camfx_s;
  logic signed [11:0] cos_c;
  logic signed [11:0] sin_c;
  logic signed [11:0] abs_s;
  logic signed [31:0] left_c;
  logic signed [31:0] p32;
  logic signed [31:0] pf;
  logic signed [31:0] zo_c;
  logic               past_end;

  logic [31:0]        fd_u;
  logic [SW-1:0]      fd_s;
  logic signed [31:0] fd_n;
  logic signed [31:0] fd_d;

  logic signed [31:0] xpc;
  logic signed [33:0] xi;
  logic signed [31:0] xp2;
  logic signed [31:0] scn;

  logic signed [31:0] diff;
  logic signed [31:0] rowq;
  logic               vis_c;
  logic [10:0]        src_c;
  logic               fin_c;

  pswc_mul u_mul (
    .clk    (clk),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .prod_r (prod_r)
  );

  pswc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .rsp   (drsp)
  );

  assign in_acc   = in_chan.valid && in_chan.ready;
  assign out_free = !out_valid_r || out_chan.ready;

  assign cam_s   = $signed({16'b0, cam_r});
  assign camfx_s = $signed({6'b0, camfx_r});
  assign cos_c   = sine_lookup(angle_r[9:0] + QUARTER_TURN);
  assign sin_c   = sine_lookup(angle_r[9:0]);
  assign abs_s   = sin_c[11] ? -sin_c : sin_c;
  assign left_c  = (32'sd1 - $signed({21'b0, win_r})) <<< (FRAC_BITS - 1);
  assign p32     = prod_r[31:0];
  assign pf      = prod_r[FRAC_BITS+31:FRAC_BITS];
  assign zo_c    = ($signed({{21{dist_r[10]}}, dist_r}) <<< FRAC_BITS) - (p32 >>> 2);

  // Normalizing shift of the divide: leading zeros minus two, clamped.
  always_comb begin
    fd_u = divn_r[31] ? ~divn_r : divn_r;
    fd_s = SW'(FRAC_BITS);
    for (int k = FRAC_BITS + 1; k >= 0; k--) begin
      if (fd_u[31-k]) begin
        fd_s = (k < 2) ? '0 : SW'(k - 2);
      end
    end
    fd_n = divn_r <<< fd_s;
    fd_d = divd_r >>> (SW'(FRAC_BITS) - fd_s);
  end

  assign xpc      = (drsp.quot < top_r) ? top_r : drsp.quot;
  assign xi       = (34'(xpc) - 34'(top_r) + ONE_M1) >>> FRAC_BITS;
  assign past_end = xi >= $signed({23'b0, axis_r});
  assign xp2      = top_r + (xi[31:0] <<< FRAC_BITS);
  assign scn      = camfx_s + zo_r + pf;

  always_comb begin
    diff  = src_r - left_r;
    rowq  = (diff + (diff[31] ? ONE_Q - 32'sd1 : 32'sd0)) >>> FRAC_BITS;
    vis_c = !rowq[31] && (rowq < $signed({21'b0, width_r}));
    fin_c = row_r >= axis_r;
    if (width_r == 11'd0 || rowq[31]) begin
      src_c = '0;
    end else if (!vis_c) begin
      src_c = width_r - 11'd1;
    end else begin
      src_c = rowq[10:0];
    end
    if (src_c > 11'd1023) begin
      src_c = 11'd1023;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_chan.operation == OP_BEGIN) begin
            state_nxt = ST_B_TILT;
          end else if (row_r >= axis_r) begin
            state_nxt = ST_RES;
          end else if (rot_r) begin
            state_nxt = ST_FDIV;
          end else begin
            state_nxt = ST_M_SC;
          end
        end
      end
      ST_B_TILT: state_nxt = ST_B_ZO;
      ST_B_ZO:   state_nxt = ST_B_LC;
      ST_B_LC:   state_nxt = ST_B_LS;
      ST_B_LS:   state_nxt = ST_B_XN;
      ST_B_XN:   state_nxt = ST_FDIV;
      ST_B_N1:   state_nxt = ST_B_N2;
      ST_B_N2:   state_nxt = ST_B_D1;
      ST_B_D1:   state_nxt = ST_B_D2;
      ST_B_D2:   state_nxt = ST_B_D3;
      ST_B_D3:   state_nxt = ST_FDIV;
      ST_FDIV:   state_nxt = ST_DIVW;
      ST_DIVW: begin
        if (drsp.done) begin
          unique case (phase_r)
            PH_XP:   state_nxt = past_end ? ST_RES : ST_B_N1;
            PH_SRC:  state_nxt = ST_M_SC;
            PH_SC:   state_nxt = ST_RES;
            default: state_nxt = ST_RES;
          endcase
        end
      end
      ST_M_SC:   state_nxt = ST_SC;
      ST_SC:     state_nxt = (cam_r == 16'd0) ? ST_RES : ST_DIVW;
      ST_RES:    state_nxt = out_free ? ST_IDLE : ST_RES;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs: shared unit operands and handshake.
  always_comb begin
    mul_a      = '0;
    mul_b      = '0;
    dreq.start = 1'b0;
    dreq.num   = fd_n;
    dreq.den   = fd_d;
    in_chan.ready = state_r == ST_IDLE;
    unique case (state_r)
      ST_B_TILT: begin
        mul_a = tilt_r >>> (FRAC_BITS - 2);
        mul_b = 32'(abs_s);
      end
      ST_B_ZO: begin
        mul_a = left_r;
        mul_b = 32'(cos_r);
      end
      ST_B_LC: begin
        mul_a = left_r;
        mul_b = 32'(sin_r);
      end
      ST_B_LS: begin
        mul_a = cam_s;
        mul_b = t_r;
      end
      ST_B_N1: begin
        mul_a = cam_s;
        mul_b = cx_r - xp_r;
      end
      ST_B_N2: begin
        mul_a = xp_r;
        mul_b = zo_r;
      end
      ST_B_D1: begin
        mul_a = xp_r;
        mul_b = 32'(sin_r);
      end
      ST_B_D2: begin
        mul_a = cam_s;
        mul_b = 32'(cos_r);
      end
      ST_M_SC: begin
        mul_a = src_r;
        mul_b = 32'(sin_r);
      end
      ST_FDIV: dreq.start = 1'b1;
      ST_SC: begin
        dreq.start = cam_r != 16'd0;
        dreq.num   = scn;
        dreq.den   = cam_s;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cam_r       <= 16'd20;
      camfx_r     <= 26'd20480;
      top_r       <= -32'sd163328;
      tilt_r      <= '0;
      axis_r      <= 11'd320;
      width_r     <= '0;
      left_r      <= '0;
      cos_r       <= '0;
      sin_r       <= '0;
      zo_r        <= '0;
      rot_r       <= 1'b0;
      num_r       <= '0;
      den_r       <= '0;
      src_r       <= '0;
      step_r      <= '0;
      row_r       <= 11'd320;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_RES && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_CAM_DIST:  cam_r   <= cfg_data[15:0];
          CFG_CAM_FIXED: camfx_r <= cfg_data[25:0];
          CFG_DISP_TOP:  top_r   <= cfg_data;
          CFG_TILT:      tilt_r  <= cfg_data;
          CFG_AXIS_LEN:  axis_r  <= cfg_data[10:0];
          default: ;
        endcase
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc && in_chan.operation == OP_ADVANCE && row_r < axis_r) begin
            row_r <= row_r + 11'd1;
            if (rot_r) begin
              num_r <= num_r + step_r;
              den_r <= den_r + 32'(sin_r);
            end else begin
              src_r <= src_r + ONE_Q;
            end
          end
        end
        ST_B_TILT: begin
          width_r <= win_r;
          left_r  <= left_c;
          cos_r   <= cos_c;
          sin_r   <= sin_c;
        end
        ST_B_ZO: begin
          zo_r  <= zo_c;
          rot_r <= (angle_r != 11'd0) || (zo_c != 32'sd0);
        end
        ST_DIVW: begin
          if (drsp.done) begin
            if (phase_r == PH_XP) begin
              if (past_end) begin
                row_r <= axis_r;
              end else begin
                row_r <= xi[10:0];
              end
            end else if (phase_r == PH_SRC) begin
              src_r <= drsp.quot;
            end
          end
        end
        ST_B_D3: begin
          num_r  <= divn_r;
          den_r  <= t_r - p32;
          step_r <= -camfx_s - zo_r;
        end
        default: ;
      endcase
    end
  end

  // Operand and scratch registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      angle_r <= in_chan.angle;
      dist_r  <= in_chan.depth_distance;
      cx_r    <= in_chan.centre_position;
      win_r   <= in_chan.slide_width;
      if (in_chan.operation == OP_ADVANCE) begin
        divn_r  <= num_r + step_r;
        divd_r  <= den_r + 32'(sin_r);
        phase_r <= PH_SRC;
      end
    end
    unique case (state_r)
      ST_B_LC: t_r <= cx_r + pf;
      ST_B_LS: divd_r <= camfx_s + zo_r + pf;
      ST_B_XN: begin
        divn_r  <= p32;
        phase_r <= PH_XP;
      end
      ST_DIVW: begin
        if (drsp.done && phase_r == PH_XP) begin
          xp_r <= xp2;
        end else if (drsp.done && phase_r == PH_SC) begin
          sc_r <= (drsp.quot <= 32'sd0) ? 31'd1 : drsp.quot[30:0];
        end
      end
      ST_B_N2: t_r <= p32;
      ST_B_D1: t_r <= t_r - pf;
      ST_B_D2: begin
        divn_r <= t_r;
        t_r    <= pf;
      end
      ST_B_D3: begin
        divd_r  <= t_r - p32;
        phase_r <= PH_SRC;
      end
      ST_SC: begin
        phase_r <= PH_SC;
        if (cam_r == 16'd0) begin
          sc_r <= 31'd1;
        end
      end
      ST_RES: begin
        if (out_free) begin
          o_row_r <= fin_c ? axis_r : row_r;
          o_vis_r <= !fin_c && vis_c;
          o_src_r <= fin_c ? 10'd0 : src_c[9:0];
          o_sc_r  <= fin_c ? 31'd1 : sc_r;
          o_fin_r <= fin_c;
        end
      end
      default: ;
    endcase
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.screen_row  = o_row_r;
  assign out_chan.visible     = o_vis_r;
  assign out_chan.source_row  = o_src_r;
  assign out_chan.cross_scale = o_sc_r;
  assign out_chan.finished    = o_fin_r;

endmodule

### hdl/pswc_checker.sv
// ----------------------------------------------------------------------------
// pswc_checker
// Port-level checks of the column walker, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pswc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_visible,
  input logic        out_finished,
  input logic [30:0] out_cross_scale,
  input logic [9:0]  out_source_row
);

  `PSWC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result beat dropped")
  `PSWC_ASSERT_NEXT(a_busy_after_in, in_valid && in_ready, !in_ready, "beat taken while busy")
  `PSWC_ASSERT_NOW(a_fin_hidden, out_valid && out_finished,
                   !out_visible && out_source_row == 10'd0, "finished row shown")
  `PSWC_ASSERT_NOW(a_scale_pos, out_valid, out_cross_scale != 31'd0, "zero cross scale")

endmodule

bind perspective_slide_column_walker_unit pswc_checker u_pswc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_chan.valid),
  .in_ready        (in_chan.ready),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .out_visible     (out_chan.visible),
  .out_finished    (out_chan.finished),
  .out_cross_scale (out_chan.cross_scale),
  .out_source_row  (out_chan.source_row)
);

### tb/pswc_checker.sv
// ----------------------------------------------------------------------------
// pswc_tb_checker
// Watches the configuration port and both channels of the column walker,
// predicts every result beat from the accepted input beats and compares the
// result beats field by field, in order.
// ----------------------------------------------------------------------------
module pswc_tb_checker
  import pswc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  pswc_in_if          in_mon,
  pswc_out_if         out_mon,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          error_count,
  output int          rows_outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [10:0] screen_row;
    logic        visible;
    logic [9:0]  source_row;
    logic [30:0] cross_scale;
    logic        finished;
  } row_beat_t;

  row_beat_t rows_due[$];

  logic [15:0] cam_dist;
  logic [25:0] cam_fixed;
  int          disp_top;
  int          tilt_comp;
  logic [10:0] axis_len;

  logic [10:0] width_q;
  int          left_q, cos_q, sin_q, zoff_q;
  logic        rotated_q;
  int          num_acc, den_acc, src_pos, num_step;
  logic [10:0] row_cnt;

  function automatic int qmul(int a, int b);
    longint p;
    p = longint'(a) * longint'(b);
    return int'(p >>> 10);
  endfunction

  function automatic int qdiv(int n, int d);
    int          sh;
    int          nn, dd;
    logic [31:0] u;
    u = (n < 0) ? ~n : n;
    if (u == 0) begin
      sh = 30;
    end else begin
      sh = 0;
      while (sh < 32 && !u[31 - sh]) sh++;
      sh = sh - 2;
    end
    if (sh > 10) sh = 10;
    if (sh < 0) sh = 0;
    nn = n << sh;
    dd = d >>> (10 - sh);
    if (dd == 0) return 0;
    if (nn == 32'sh8000_0000 && dd == -1) return nn;
    return nn / dd;
  endfunction

  function automatic int interp_sine(logic [10:0] a);
    int ai, i, p, g;
    ai = a & 11'h3FF;
    i  = ai / 16;
    p  = int'(SINE_TBL[i]);
    g  = int'(SINE_TBL[i + 1]) - p;
    return p + (g * (ai - i * 16)) / 16;
  endfunction

  task automatic begin_slide(logic [10:0] ang, int depth, int cx, logic [10:0] w);
    int     abs_s, tiltv, xp, cam, camfx;
    longint xi;
    cam     = int'(cam_dist);
    camfx   = int'(cam_fixed);
    cos_q   = interp_sine(ang + 11'd256);
    sin_q   = interp_sine(ang);
    abs_s   = (sin_q < 0) ? -sin_q : sin_q;
    tiltv   = int'(longint'(tilt_comp >>> 8) * longint'(abs_s));
    zoff_q  = 1024 * depth - (tiltv >>> 2);
    width_q = w;
    left_q  = 512 - int'(w) * 512;
    rotated_q = (ang != 0) || (zoff_q != 0);
    xp = qdiv(cam * (cx + qmul(left_q, cos_q)), camfx + zoff_q + qmul(left_q, sin_q));
    if (xp < disp_top) xp = disp_top;
    xi = (longint'(xp) - longint'(disp_top) + 1023) >>> 10;
    if (xi >= longint'(axis_len)) begin
      row_cnt = axis_len;
    end else begin
      xp       = disp_top + int'(xi) * 1024;
      num_acc  = cam * (cx - xp) - qmul(xp, zoff_q);
      den_acc  = qmul(xp, sin_q) - cam * cos_q;
      src_pos  = qdiv(num_acc, den_acc);
      num_step = -camfx - zoff_q;
      row_cnt  = xi[10:0];
    end
  endtask

  function automatic row_beat_t project_row();
    row_beat_t r;
    int        row, src, num;
    longint    sc;
    if (row_cnt >= axis_len) begin
      r = '{screen_row: axis_len, visible: 1'b0, source_row: '0, cross_scale: 31'd1,
            finished: 1'b1};
      return r;
    end
    row = (src_pos - left_q) / 1024;
    if (width_q == 0 || row < 0) src = 0;
    else if (row >= int'(width_q)) src = int'(width_q) - 1;
    else src = row;
    if (src > 1023) src = 1023;
    if (cam_dist == 0) begin
      sc = 1;
    end else begin
      num = int'(cam_fixed) + zoff_q + qmul(src_pos, sin_q);
      sc  = longint'(num) / longint'(cam_dist);
      if (sc <= 0) sc = 1;
    end
    r.screen_row  = row_cnt;
    r.visible     = (row >= 0 && row < int'(width_q));
    r.source_row  = src[9:0];
    r.cross_scale = sc[30:0];
    r.finished    = 1'b0;
    return r;
  endfunction

  always @(posedge clk) begin
    row_beat_t want, got;
    if (!rst_n) begin
      cam_dist  = 16'd20;
      cam_fixed = 26'd20480;
      disp_top  = -163328;
      tilt_comp = 0;
      axis_len  = 11'd320;
      width_q = '0; left_q = 0; cos_q = 0; sin_q = 0; zoff_q = 0; rotated_q = 1'b0;
      num_acc = 0; den_acc = 0; src_pos = 0; num_step = 0;
      row_cnt = 11'd320;
      rows_due.delete();
      error_count      <= 0;
      rows_outstanding <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_CAM_DIST:  cam_dist  = cfg_data[15:0];
          CFG_CAM_FIXED: cam_fixed = cfg_data[25:0];
          CFG_DISP_TOP:  disp_top  = cfg_data;
          CFG_TILT:      tilt_comp = cfg_data;
          CFG_AXIS_LEN:  axis_len  = cfg_data[10:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        if (op_t'(in_mon.operation) == OP_ADVANCE) begin
          if (row_cnt < axis_len) begin
            if (rotated_q) begin
              num_acc = num_acc + num_step;
              den_acc = den_acc + sin_q;
              src_pos = qdiv(num_acc, den_acc);
            end else begin
              src_pos = src_pos + 1024;
            end
            row_cnt = row_cnt + 11'd1;
          end
        end else begin
          begin_slide(in_mon.angle, int'(in_mon.depth_distance),
                      in_mon.centre_position, in_mon.slide_width);
        end
        rows_due.push_back(project_row());
      end
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.screen_row, out_mon.visible, out_mon.source_row,
                out_mon.cross_scale, out_mon.finished};
        if (rows_due.size() == 0) begin
          $display("%0t: unexpected result beat %p", $time, got);
          error_count <= error_count + 1;
        end else begin
          want = rows_due.pop_front();
          if (got != want) begin
            $display("%0t: result mismatch, expected %p, actual %p", $time, want, got);
            error_count <= error_count + 1;
          end
        end
      end
      rows_outstanding <= rows_due.size();
    end
  end

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the column walker: directed slides at the field extremes, then
// random slide walks under several register settings, with random gaps and
// stalls on both channels and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top;
  import pswc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  int          error_count;
  int          rows_outstanding;
  int          beats_sent = 0;
  int          hold_off_request = 0;

  pswc_in_if  in_if();
  pswc_out_if out_if();

  perspective_slide_column_walker_unit DUT (
    .clk(clk), .rst_n(rst_n), .in_chan(in_if), .out_chan(out_if),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  pswc_tb_checker u_checker (
    .clk(clk), .rst_n(rst_n), .in_mon(in_if), .out_mon(out_if),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .error_count(error_count), .rows_outstanding(rows_outstanding)
  );

  always #6 clk = ~clk;

  initial begin
    #100_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int stall, quiet;
    out_if.ready = 1'b0;
    stall = 0;
    quiet = 0;
    forever begin
      @(negedge clk);
      if (hold_off_request > 0) begin
        out_if.ready = 1'b0;
        hold_off_request--;
      end else if (stall > 0) begin
        out_if.ready = 1'b0;
        stall--;
      end else if (quiet > 0) begin
        out_if.ready = 1'b1;
        quiet--;
      end else begin
        case ($urandom_range(0, 19))
          0:       quiet = $urandom_range(50, 400);
          1:       stall = $urandom_range(20, 90);
          2, 3, 4: stall = $urandom_range(1, 4);
          default: ;
        endcase
        out_if.ready = (stall == 0);
      end
    end
  end

  task automatic send_beat(op_t op, logic [10:0] ang, logic [10:0] depth, logic [31:0] cx,
                           logic [10:0] w);
    int gap;
    case ($urandom_range(0, 9))
      0:       gap = $urandom_range(20, 80);
      1, 2, 3: gap = $urandom_range(1, 4);
      default: gap = 0;
    endcase
    if (gap > 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.operation       = op;
    in_if.angle           = ang;
    in_if.depth_distance  = depth;
    in_if.centre_position = cx;
    in_if.slide_width     = w;
    in_if.valid           = 1'b1;
    do @(posedge clk); while (!in_if.ready);
    @(negedge clk);
    beats_sent++;
    if (beats_sent == 300) hold_off_request = 700;
  endtask

  task automatic advance_rows(int n);
    repeat (n) send_beat(OP_ADVANCE, 11'($urandom), 11'($urandom), $urandom, 11'($urandom));
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [31:0] value);
    cfg_index = idx;
    cfg_data  = value;
    cfg_we    = 1'b1;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  task automatic wait_idle();
    in_if.valid = 1'b0;
    @(negedge clk);
    while (rows_outstanding != 0 || out_if.valid) @(negedge clk);
    repeat (150) @(negedge clk);
  endtask

  task automatic load_setting(logic [31:0] cam, logic [31:0] camfx, logic [31:0] top,
                              logic [31:0] tilt, logic [31:0] axis);
    wait_idle();
    write_reg(CFG_CAM_DIST, cam);
    write_reg(CFG_CAM_FIXED, camfx);
    write_reg(CFG_DISP_TOP, top);
    write_reg(CFG_TILT, tilt);
    write_reg(CFG_AXIS_LEN, axis);
  endtask

  task automatic random_walks(int beats);
    int          n, k;
    logic [10:0] w;
    n = 0;
    while (n < beats) begin
      k = $urandom_range(0, 9);
      if (k == 0) begin
        send_beat(OP_BEGIN, 11'($urandom), 11'($urandom), $urandom, 11'($urandom));
        n++;
      end else if (k == 1) begin
        advance_rows(1);
        n++;
      end else begin
        w = ($urandom_range(0, 9) == 0) ? 11'($urandom_range(1, 1024))
                                          : 11'($urandom_range(1, 300));
        send_beat(OP_BEGIN, 11'($urandom), 11'($urandom_range(0, 80) - 40),
                  ($urandom_range(0, 400) - 200) * 1024 + $urandom_range(0, 1023), w);
        k = $urandom_range(0, 40);
        advance_rows(k);
        n += k + 1;
      end
    end
  endtask

  initial begin
    in_if.valid           = 1'b0;
    in_if.operation       = OP_BEGIN;
    in_if.angle           = '0;
    in_if.depth_distance  = '0;
    in_if.centre_position = '0;
    in_if.slide_width     = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    advance_rows(1);
    send_beat(OP_BEGIN, 11'd0, 11'd0, 32'd0, 11'd64);
    advance_rows(3);
    send_beat(OP_BEGIN, -11'sd1024, 11'd1023, 32'h7FFF_FFFF, 11'd1024);
    advance_rows(2);
    send_beat(OP_BEGIN, 11'd1023, -11'sd1024, 32'h8000_0000, 11'd1);
    advance_rows(2);
    send_beat(OP_BEGIN, 11'd256, 11'd5, 32'd0, 11'd0);
    advance_rows(2);
    send_beat(OP_BEGIN, 11'd512, 11'd0, -32'sd4096, 11'd2047);
    advance_rows(2);
    send_beat(OP_BEGIN, 11'd768, 11'd1, 32'd1000, 11'd300);
    advance_rows(2);

    load_setting(20, 20480, -163328, 300 * 1024, 320);
    random_walks(350);
    load_setting(65535, 32'h03FF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1024);
    random_walks(200);
    load_setting(1, 1, 32'h8000_0000, 32'h8000_0000, 1);
    random_walks(200);
    load_setting(0, 20480, -163328, -50000, 1024);
    random_walks(250);
    load_setting(20, 20480, -163328, 0, 320);
    random_walks(300);
    load_setting($urandom_range(1, 100), $urandom_range(1024, 100000),
                 -$urandom_range(0, 300 * 1024), $urandom, $urandom_range(1, 1024));
    random_walks(300);
    load_setting($urandom, $urandom, $urandom, $urandom, $urandom);
    random_walks(150);
    load_setting(20, 20480, -163328, 100 * 1024, 200);
    random_walks(250);

    in_if.valid = 1'b0;
    while (rows_outstanding != 0 || out_if.valid) @(negedge clk);
    repeat (200) @(negedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
